[sv/positional_list_engine_assert.svh]
// Assertion macros for the positional list engine.
// Used by positional_list_engine.sv; expects clk and rst in scope.
`ifndef POSITIONAL_LIST_ENGINE_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PLE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define PLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[sv/ple_pkg.sv]
// Types and constants for the positional list engine.
// No dependencies.
package ple_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = CNT_W;
  localparam int VAL_W    = 32;
  localparam int REQ_W    = 4;
  localparam int STAT_W   = 2;

  // request payload layout
  localparam int S_RAW_W  = VAL_W + POS_W;
  localparam int S_DATA_W = ((S_RAW_W + 7) / 8) * 8;

  // result payload layout
  localparam int M_RD_LO  = STAT_W;
  localparam int M_CNT_LO = M_RD_LO + VAL_W;
  localparam int M_EMP_LO = M_CNT_LO + CNT_W;
  localparam int M_RAW_W  = M_EMP_LO + 1;
  localparam int M_DATA_W = ((M_RAW_W + 7) / 8) * 8;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD_FRONT = 4'd0,
    REQ_ADD_BACK  = 4'd1,
    REQ_INSERT    = 4'd2,
    REQ_DEL_FRONT = 4'd3,
    REQ_DEL_BACK  = 4'd4,
    REQ_DEL_AT    = 4'd5,
    REQ_READ      = 4'd6,
    REQ_WRITE     = 4'd7,
    REQ_CLEAR     = 4'd8
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_FULL  = 2'd3
  } stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP,
    ST_UPL,
    ST_DN,
    ST_DNL,
    ST_RDW,
    ST_PUT,
    ST_FIN
  } state_t;

  // outcome of a request, decided when it is accepted
  typedef struct packed {
    state_t            nxt;
    stat_t             status;
    logic [CNT_W-1:0]  count;
    logic [IDX_W-1:0]  ptr;
    logic [IDX_W-1:0]  lim;
    logic              mem_wr;
  } dec_t;

endpackage

[sv/positional_list_engine.sv]
// Positional list engine: ordered list of signed 32-bit values in one memory.
// Depends on ple_pkg and positional_list_engine_assert.svh.
//
// One request is taken at a time; s_tready is high while the engine is idle,
// also while a finished result still waits in the output register. Write,
// clear, rejected and unknown requests and deletes that move nothing go
// straight to ST_FIN; a read passes ST_RDW, an insert at the end ST_PUT.
// Insert at position p with count c moves c-p elements through ST_UP, ST_UPL
// and ST_PUT; delete at p moves c-p-1 elements through ST_DN and ST_DNL.
// ST_FIN loads the result once the output is free, so a stalled result holds
// the engine, and the next request is taken no earlier than after the load.
// The shift rate is one element per cycle, set by the single write port of
// the element memory. No clearing pass follows reset.
`include "positional_list_engine_assert.svh"

module positional_list_engine
  import ple_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // [31:0] value, [38:32] position, zero pad above
  input  logic [S_DATA_W-1:0] s_tdata,
  // [3:0] req_type
  input  logic [REQ_W-1:0]    s_tuser,
  output logic                m_tvalid,
  input  logic                m_tready,
  // [1:0] status, [33:2] read_value, [40:34] count, [41] empty flag, zero pad
  output logic [M_DATA_W-1:0] m_tdata
);

  logic [VAL_W-1:0] mem [CAPACITY];
  logic [VAL_W-1:0] mem_q;
  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  logic [IDX_W-1:0] mem_ra;
  logic [VAL_W-1:0] mem_wd;

  state_t           state, state_next;
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] ptr;
  logic [IDX_W-1:0] lim;
  logic             wp;
  logic [IDX_W-1:0] wa;
  logic [IDX_W-1:0] pa;
  logic [VAL_W-1:0] pv;
  stat_t            res_status;
  logic [VAL_W-1:0] res_rd;

  req_t             req;
  logic [VAL_W-1:0] value;
  logic [POS_W-1:0] position;
  logic [CNT_W-1:0] ins_at;
  logic [CNT_W-1:0] del_at;
  dec_t             dec;
  logic             accept;
  logic             out_free;
  logic             ins_req;
  logic             ins_full;
  logic [CNT_W-1:0] out_cnt;

  assign req      = req_t'(s_tuser);
  assign value    = s_tdata[VAL_W-1:0];
  assign position = s_tdata[VAL_W +: POS_W];
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign ins_at = (req == REQ_ADD_FRONT) ? '0 :
                  (req == REQ_ADD_BACK)  ? count : position;
  assign del_at = (req == REQ_DEL_FRONT) ? '0 :
                  (req == REQ_DEL_BACK)  ? count - CNT_W'(1) : position;

  // request decode against the current count
  always_comb begin
    dec        = '0;
    dec.nxt    = ST_FIN;
    dec.status = STAT_OK;
    dec.count  = count;
    case (req)
      REQ_ADD_FRONT, REQ_ADD_BACK, REQ_INSERT: begin
        if (ins_at > count) begin
          dec.status = STAT_RANGE;
        end else if (count >= CNT_W'(CAPACITY)) begin
          dec.status = STAT_FULL;
        end else begin
          dec.count = count + CNT_W'(1);
          if (ins_at < count) begin
            dec.nxt = ST_UP;
            dec.ptr = IDX_W'(count - CNT_W'(1));
            dec.lim = ins_at[IDX_W-1:0];
          end else begin
            dec.nxt = ST_PUT;
          end
        end
      end
      REQ_DEL_FRONT, REQ_DEL_BACK, REQ_DEL_AT: begin
        if (count == '0) begin
          dec.status = STAT_EMPTY;
        end else if (del_at >= count) begin
          dec.status = STAT_RANGE;
        end else begin
          dec.count = count - CNT_W'(1);
          if (del_at < count - CNT_W'(1)) begin
            dec.nxt = ST_DN;
            dec.ptr = IDX_W'(del_at + CNT_W'(1));
            dec.lim = IDX_W'(count - CNT_W'(1));
          end
        end
      end
      REQ_READ, REQ_WRITE: begin
        if (count == '0) begin
          dec.status = STAT_EMPTY;
        end else if (position >= count) begin
          dec.status = STAT_RANGE;
        end else if (req == REQ_READ) begin
          dec.nxt = ST_RDW;
        end else begin
          dec.mem_wr = 1'b1;
        end
      end
      REQ_CLEAR: begin
        dec.count = '0;
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (s_tvalid) state_next = dec.nxt;
      ST_UP:   if (ptr == lim) state_next = ST_UPL;
      ST_UPL:  state_next = ST_PUT;
      ST_DN:   if (ptr == lim) state_next = ST_DNL;
      ST_DNL:  state_next = ST_FIN;
      ST_RDW:  state_next = ST_FIN;
      ST_PUT:  state_next = ST_FIN;
      ST_FIN:  if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    s_tready = 1'b0;
    mem_we   = 1'b0;
    mem_wa   = wa;
    mem_wd   = mem_q;
    mem_ra   = ptr;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        mem_ra   = position[IDX_W-1:0];
        mem_we   = s_tvalid && dec.mem_wr;
        mem_wa   = position[IDX_W-1:0];
        mem_wd   = value;
      end
      ST_UP, ST_DN: begin
        mem_we = wp;
      end
      ST_UPL, ST_DNL: begin
        mem_we = 1'b1;
      end
      ST_PUT: begin
        mem_we = 1'b1;
        mem_wa = pa;
        mem_wd = pv;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_q <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      wp       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        count      <= dec.count;
        res_status <= dec.status;
        res_rd     <= '0;
        ptr        <= dec.ptr;
        lim        <= dec.lim;
        wp         <= 1'b0;
        pa         <= ins_at[IDX_W-1:0];
        pv         <= value;
      end
      case (state)
        ST_UP: begin
          // element read now lands one slot higher next cycle
          wp <= 1'b1;
          wa <= ptr + IDX_W'(1);
          if (ptr != lim) ptr <= ptr - IDX_W'(1);
        end
        ST_DN: begin
          wp <= 1'b1;
          wa <= ptr - IDX_W'(1);
          if (ptr != lim) ptr <= ptr + IDX_W'(1);
        end
        ST_RDW: res_rd <= mem_q;
        default: begin
        end
      endcase
      if (state == ST_FIN && out_free) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {(M_DATA_W - M_RAW_W)'(0), (count == '0), count, res_rd,
                     res_status};
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign ins_req  = req inside {REQ_ADD_FRONT, REQ_ADD_BACK, REQ_INSERT};
  assign ins_full = accept && ins_req && (count == CNT_W'(CAPACITY));
  assign out_cnt  = m_tdata[M_CNT_LO +: CNT_W];

  `PLE_ASSERT_NOW(a_count_cap, 1'b1, count <= CNT_W'(CAPACITY), "count above capacity")
  `PLE_ASSERT_NEXT(a_full_hold, ins_full, $stable(count) && res_status != STAT_OK, "full insert")
  `PLE_ASSERT_NOW(a_empty_flag, m_tvalid, m_tdata[M_EMP_LO] == (out_cnt == '0), "bad empty flag")
  `PLE_ASSERT_NOW(a_shift_wr, (state == ST_UPL || state == ST_DNL), wp, "shift write not pending")

endmodule
